>>> design/three_step_phase_shift_decode_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the three-step phase-shift decode unit
// Concurrent assertion wrappers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef THREE_STEP_PHASE_SHIFT_DECODE_UNIT_MACROS_SVH
`define THREE_STEP_PHASE_SHIFT_DECODE_UNIT_MACROS_SVH
`ifndef SYNTH
`define TPSD_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define TPSD_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TPSD_ASSERT_IMPLY(name, clk, rst, ante, cons, msg)
`define TPSD_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif
`endif

>>> design/tpsd_pkg.sv
// ----------------------------------------------------------------------------
// Three-step phase-shift decode package
// Word types, fixed-point constants and the arctangent table.
// ----------------------------------------------------------------------------
package tpsd_pkg;

   localparam int ANG_FRAC     = 16;
   localparam int CORDIC_STEPS = 20;
   localparam int NUM_W        = 9;
   localparam int DEN_W        = 10;
   localparam int SQRT3_W      = 18;
   localparam int XY_W         = 29;
   localparam int ANG_W        = 27;
   localparam int PHASE_W      = 15;

   localparam logic signed [SQRT3_W-1:0] SQRT3_Q16 = 18'sd113512;

   localparam logic signed [ANG_W-1:0] ANGLE_90    = 27'sd5898240;
   localparam logic signed [ANG_W-1:0] ANGLE_180   = 27'sd11796480;
   localparam logic signed [ANG_W-1:0] ANGLE_270   = 27'sd17694720;
   localparam logic signed [ANG_W-1:0] ANGLE_360   = 27'sd23592960;
   localparam logic signed [ANG_W-1:0] ANGLE_LIMIT = 27'sd23560192;

   localparam int ATAN_DEG_Q16 [CORDIC_STEPS] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
   };

   typedef enum logic [2:0] {
      SEL_CORDIC,
      SEL_ZERO,
      SEL_QUARTER,
      SEL_HALF,
      SEL_THREE_QUARTER,
      SEL_NO_MOD
   } angle_sel_type;

   typedef struct packed {
      angle_sel_type sel;
      logic          half_turn;
   } meta_type;

   typedef struct packed {
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [ANG_W-1:0] z;
   } cordic_type;

   typedef struct packed {
      logic [7:0] intensity_first;
      logic [7:0] intensity_second;
      logic [7:0] intensity_third;
   } req_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase_angle;
      logic               no_modulation;
   } rsp_type;

endpackage

>>> design/three_step_phase_shift_decode_unit.sv
// ----------------------------------------------------------------------------
// Three-step phase-shift decode unit
// Turns one pixel's three fringe intensities into a wrapped phase in degrees.
//
//   Channel  Direction  Handshake           Word
//   req      in         req_valid/req_stall intensity_first/second/third
//   rsp      out        rsp_valid/rsp_stall phase_angle, no_modulation
//
// One word enters per cycle while req_stall is low.
// The path runs through the 20 CORDIC rotation stages between one input
// stage and two finishing stages, each a register with its own valid bit.
// Reset clears all valid bits.
// A stall on rsp holds only occupied stages, so empty stages keep filling.
// ----------------------------------------------------------------------------
`include "three_step_phase_shift_decode_unit_macros.svh"

module three_step_phase_shift_decode_unit #(
   parameter int PHASE_FRACTION_BITS = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tpsd_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tpsd_pkg::rsp_type rsp_word
);
   import tpsd_pkg::*;

   logic       chain_valid [CORDIC_STEPS+1];
   logic       chain_stall [CORDIC_STEPS+1];
   cordic_type chain_vec   [CORDIC_STEPS+1];
   meta_type   chain_meta  [CORDIC_STEPS+1];

   tpsd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_stall (req_stall),
      .up_word  (req_word),
      .dn_valid (chain_valid[0]),
      .dn_stall (chain_stall[0]),
      .dn_vec   (chain_vec[0]),
      .dn_meta  (chain_meta[0])
   );

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
      tpsd_cordic_stage #(
         .STEP (k)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .up_valid (chain_valid[k]),
         .up_stall (chain_stall[k]),
         .up_vec   (chain_vec[k]),
         .up_meta  (chain_meta[k]),
         .dn_valid (chain_valid[k+1]),
         .dn_stall (chain_stall[k+1]),
         .dn_vec   (chain_vec[k+1]),
         .dn_meta  (chain_meta[k+1])
      );
   end

   tpsd_back #(
      .PHASE_FRACTION_BITS (PHASE_FRACTION_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .up_valid (chain_valid[CORDIC_STEPS]),
      .up_stall (chain_stall[CORDIC_STEPS]),
      .up_vec   (chain_vec[CORDIC_STEPS]),
      .up_meta  (chain_meta[CORDIC_STEPS]),
      .dn_valid (rsp_valid),
      .dn_stall (rsp_stall),
      .dn_word  (rsp_word)
   );

   `TPSD_ASSERT_IMPLY(a_no_mod_zero, clock, reset,
      rsp_valid && rsp_word.no_modulation, rsp_word.phase_angle == '0,
      "No-modulation word carries a nonzero phase.")
   `TPSD_ASSERT_IMPLY(a_stall_full, clock, reset,
      req_stall, rsp_valid && rsp_stall,
      "Input stalled while the output is not held.")
   `TPSD_ASSERT_NEXT(a_tail_hold, clock, reset,
      chain_valid[CORDIC_STEPS] && chain_stall[CORDIC_STEPS], chain_valid[CORDIC_STEPS],
      "Held CORDIC word was dropped.")
   `TPSD_ASSERT_IMPLY(a_phase_range, clock, reset,
      rsp_valid && PHASE_FRACTION_BITS == 6, rsp_word.phase_angle <= 15'd23008,
      "Phase beyond its range.")

endmodule

>>> design/tpsd_front.sv
// ----------------------------------------------------------------------------
// Front stage
// Forms numerator and denominator, folds the left half plane and classifies.
// ----------------------------------------------------------------------------
module tpsd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                up_valid,
   output logic                up_stall,
   input  tpsd_pkg::req_type   up_word,
   output logic                dn_valid,
   input  logic                dn_stall,
   output tpsd_pkg::cordic_type dn_vec,
   output tpsd_pkg::meta_type  dn_meta
);
   import tpsd_pkg::*;

   logic                              valid_ff;
   cordic_type                        vec_ff, vec_in;
   meta_type                          meta_ff, meta_in;
   logic signed [NUM_W-1:0]           num;
   logic signed [DEN_W-1:0]           den;
   logic signed [DEN_W-1:0]           den_mag;
   logic signed [NUM_W-1:0]           num_adj;
   logic signed [NUM_W+SQRT3_W-1:0]   prod;

   always_comb begin
      num = $signed({1'b0, up_word.intensity_first}) - $signed({1'b0, up_word.intensity_third});
      den = $signed({1'b0, up_word.intensity_second, 1'b0})
            - $signed({2'b00, up_word.intensity_first})
            - $signed({2'b00, up_word.intensity_third});
      den_mag = den[DEN_W-1] ? -den : den;
      num_adj = den[DEN_W-1] ? -num : num;
      prod    = num_adj * SQRT3_Q16;
      vec_in.x = {{(XY_W-DEN_W-ANG_FRAC){1'b0}}, den_mag, {ANG_FRAC{1'b0}}};
      vec_in.y = XY_W'(prod);
      vec_in.z = '0;
      meta_in.half_turn = den[DEN_W-1];
      if (num == '0 && den == '0) begin
         meta_in.sel = SEL_NO_MOD;
      end else if (num == '0) begin
         meta_in.sel = den[DEN_W-1] ? SEL_HALF : SEL_ZERO;
      end else if (den == '0) begin
         meta_in.sel = num[NUM_W-1] ? SEL_THREE_QUARTER : SEL_QUARTER;
      end else begin
         meta_in.sel = SEL_CORDIC;
      end
   end

   assign up_stall = valid_ff && dn_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!up_stall) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!up_stall && up_valid) begin
         vec_ff  <= vec_in;
         meta_ff <= meta_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_vec   = vec_ff;
   assign dn_meta  = meta_ff;

endmodule

>>> design/tpsd_cordic_stage.sv
// ----------------------------------------------------------------------------
// CORDIC stage
// One registered vectoring-mode rotation with a fixed shift amount.
// ----------------------------------------------------------------------------
module tpsd_cordic_stage #(
   parameter int STEP = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 up_valid,
   output logic                 up_stall,
   input  tpsd_pkg::cordic_type up_vec,
   input  tpsd_pkg::meta_type   up_meta,
   output logic                 dn_valid,
   input  logic                 dn_stall,
   output tpsd_pkg::cordic_type dn_vec,
   output tpsd_pkg::meta_type   dn_meta
);
   import tpsd_pkg::*;

   localparam logic signed [ANG_W-1:0] ATAN_STEP = ANG_W'(ATAN_DEG_Q16[STEP]);

   logic                   valid_ff;
   cordic_type             vec_ff, vec_in;
   meta_type               meta_ff;
   logic signed [XY_W-1:0] dx;
   logic signed [XY_W-1:0] dy;

   always_comb begin
      dx = up_vec.y >>> STEP;
      dy = up_vec.x >>> STEP;
      if (!up_vec.y[XY_W-1] && up_vec.y != '0) begin
         vec_in.x = up_vec.x + dx;
         vec_in.y = up_vec.y - dy;
         vec_in.z = up_vec.z + ATAN_STEP;
      end else begin
         vec_in.x = up_vec.x - dx;
         vec_in.y = up_vec.y + dy;
         vec_in.z = up_vec.z - ATAN_STEP;
      end
   end

   assign up_stall = valid_ff && dn_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!up_stall) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!up_stall && up_valid) begin
         vec_ff  <= vec_in;
         meta_ff <= up_meta;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_vec   = vec_ff;
   assign dn_meta  = meta_ff;

endmodule

>>> design/tpsd_back.sv
// ----------------------------------------------------------------------------
// Back stages
// Restores the quadrant, wraps the angle, rounds and holds the result word.
// ----------------------------------------------------------------------------
module tpsd_back #(
   parameter int PHASE_FRACTION_BITS = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 up_valid,
   output logic                 up_stall,
   input  tpsd_pkg::cordic_type up_vec,
   input  tpsd_pkg::meta_type   up_meta,
   output logic                 dn_valid,
   input  logic                 dn_stall,
   output tpsd_pkg::rsp_type    dn_word
);
   import tpsd_pkg::*;

   localparam int SHIFT = ANG_FRAC - PHASE_FRACTION_BITS;
   localparam logic [ANG_W-1:0] ROUND_HALF = ANG_W'(2 ** (SHIFT - 1));

   logic                    wrap_valid_ff;
   logic                    wrap_stall;
   logic signed [ANG_W-1:0] ang_ff, ang_in;
   logic                    no_mod_ff;
   logic                    out_valid_ff;
   rsp_type                 out_ff, out_in;
   logic [ANG_W-1:0]        ang_kept;
   logic [ANG_W-1:0]        rounded;
   logic [ANG_W-1:0]        shifted;

   always_comb begin
      case (up_meta.sel)
         SEL_CORDIC: begin
            if (up_meta.half_turn) begin
               ang_in = up_vec.z + ANGLE_180;
            end else if (up_vec.z[ANG_W-1]) begin
               ang_in = up_vec.z + ANGLE_360;
            end else begin
               ang_in = up_vec.z;
            end
         end
         SEL_QUARTER:       ang_in = ANGLE_90;
         SEL_HALF:          ang_in = ANGLE_180;
         SEL_THREE_QUARTER: ang_in = ANGLE_270;
         default:           ang_in = '0;
      endcase
   end

   assign wrap_stall = wrap_valid_ff && out_valid_ff && dn_stall;
   assign up_stall   = wrap_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_valid_ff <= 1'b0;
      end else if (!wrap_stall) begin
         wrap_valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!wrap_stall && up_valid) begin
         ang_ff    <= ang_in;
         no_mod_ff <= (up_meta.sel == SEL_NO_MOD);
      end
   end

   always_comb begin
      ang_kept = (ang_ff > ANGLE_LIMIT) ? '0 : $unsigned(ang_ff);
      rounded  = ang_kept + ROUND_HALF;
      shifted  = rounded >> SHIFT;
      out_in.phase_angle   = shifted[PHASE_W-1:0];
      out_in.no_modulation = no_mod_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!(out_valid_ff && dn_stall)) begin
         out_valid_ff <= wrap_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!(out_valid_ff && dn_stall) && wrap_valid_ff) begin
         out_ff <= out_in;
      end
   end

   assign dn_valid = out_valid_ff;
   assign dn_word  = out_ff;

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the three-step phase-shift decode unit
// Streams pixel triplets into the unit, predicts each phase word with an
// independent fixed-point CORDIC model and checks every output word in order.
// Runs directed corner pixels, then random pixels under four mixes of input
// gaps and output stalls, including one long output hold that backs up the
// whole pipeline.
// ----------------------------------------------------------------------------
module tb;
   import tpsd_pkg::req_type;
   import tpsd_pkg::rsp_type;
   import tpsd_pkg::PHASE_W;

   localparam int     PHASE_FRAC   = 6;
   localparam int     ANGLE_FRAC   = 16;
   localparam int     ROTATIONS    = 20;
   localparam longint ROOT3_Q16    = 113512;
   localparam longint ATAN_Q16 [ROTATIONS] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
   };
   localparam int     LATENCY      = 23;
   localparam int     HOLD_CYCLES  = 400;
   localparam int     CYCLE_LIMIT  = 200000;
   localparam int     PHASE_ITEMS  = 412;

   typedef struct {
      req_type pixel;
      rsp_type phase;
   } phase_entry_type;

   class phase_scoreboard;
      phase_entry_type pending[$];
      int              checked;
      int              flat_pixels;
      int              errors;

      function rsp_type decode_phase(req_type pixel);
         longint  one, num, den, x, y, z, dx, dy, ang, rounded;
         int      step;
         rsp_type res;
         one = longint'(1) << ANGLE_FRAC;
         num = longint'(pixel.intensity_first) - longint'(pixel.intensity_third);
         den = 2 * longint'(pixel.intensity_second) - longint'(pixel.intensity_first)
               - longint'(pixel.intensity_third);
         res = '0;
         if (num == 0 && den == 0) begin
            res.no_modulation = 1'b1;
            return res;
         end
         if (num == 0) begin
            ang = (den > 0) ? 0 : 180 * one;
         end else if (den == 0) begin
            ang = (num > 0) ? 90 * one : 270 * one;
         end else begin
            x = den * one;
            y = num * ROOT3_Q16;
            ang = 0;
            if (x < 0) begin
               x = -x;
               y = -y;
               ang = 180 * one;
            end
            z = 0;
            for (step = 0; step < ROTATIONS; step++) begin
               dx = y >>> step;
               dy = x >>> step;
               if (y > 0) begin
                  x += dx;
                  y -= dy;
                  z += ATAN_Q16[step];
               end else begin
                  x -= dx;
                  y += dy;
                  z -= ATAN_Q16[step];
               end
            end
            ang += z;
            if (ang < 0) begin
               ang += 360 * one;
            end
         end
         if (ang > 359 * one + one / 2) begin
            ang = 0;
         end
         rounded = (ang + (longint'(1) << (ANGLE_FRAC - 1 - PHASE_FRAC)))
                   >> (ANGLE_FRAC - PHASE_FRAC);
         res.phase_angle = rounded[PHASE_W-1:0];
         return res;
      endfunction

      function void note_pixel(req_type pixel);
         phase_entry_type entry;
         entry.pixel = pixel;
         entry.phase = decode_phase(pixel);
         if (entry.phase.no_modulation) begin
            flat_pixels++;
         end
         pending.insert(pending.size(), entry);
      endfunction

      function void check_phase(rsp_type got);
         phase_entry_type entry;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("Unexpected phase word: phase %0d no_modulation %0b",
                        got.phase_angle, got.no_modulation);
            end
            return;
         end
         entry = pending.pop_front();
         checked++;
         if (got.phase_angle !== entry.phase.phase_angle
             || got.no_modulation !== entry.phase.no_modulation) begin
            errors++;
            if (errors <= 10) begin
               $display("Mismatch for pixel %0d/%0d/%0d: expected %0d/%0b, got %0d/%0b",
                        entry.pixel.intensity_first, entry.pixel.intensity_second,
                        entry.pixel.intensity_third, entry.phase.phase_angle,
                        entry.phase.no_modulation, got.phase_angle, got.no_modulation);
            end
         end
      endfunction

      function bit clean();
         if (pending.size() != 0) begin
            $display("%0d expected phase words never arrived.", pending.size());
         end
         return errors == 0 && pending.size() == 0;
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_word = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_word;

   phase_scoreboard board = new();

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int blocked_cycles = 0;
   int cycle_count = 0;

   three_step_phase_shift_decode_unit #(
      .PHASE_FRACTION_BITS(PHASE_FRAC)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word (rsp_word)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles.", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            board.note_pixel(req_word);
         end
         if (req_valid && req_stall) begin
            blocked_cycles <= blocked_cycles + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            board.check_phase(rsp_word);
         end
      end
   end

   // A hold request stalls the output for a long stretch so that the pipeline fills.
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_pixel(input logic [7:0] first, input logic [7:0] second,
                             input logic [7:0] third);
      req_type pixel;
      pixel.intensity_first = first;
      pixel.intensity_second = second;
      pixel.intensity_third = third;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= pixel;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   task automatic send_random_pixel();
      logic [7:0] first, second, third;
      first = 8'($urandom_range(255));
      second = 8'($urandom_range(255));
      third = 8'($urandom_range(255));
      case ($urandom_range(9))
         0, 1, 2, 3: begin
         end
         4: begin
            third = first;
         end
         5: begin
            third[0] = first[0];
            second = 8'((9'(first) + 9'(third)) >> 1);
         end
         6: begin
            second = first;
            third = first;
         end
         7: begin
            first = 8'($urandom_range(100));
            third = first + 8'd1;
            second = 8'($urandom_range(255, first + 100));
            if ($urandom_range(1)) begin
               third = first;
               first = first + 8'd1;
            end
         end
         8: begin
            second = first ^ 8'($urandom_range(3));
            third = first ^ 8'($urandom_range(3));
         end
         default: begin
            first = $urandom_range(1) ? 8'hFF : 8'h00;
            second = $urandom_range(1) ? 8'hFF : 8'h00;
            third = $urandom_range(1) ? 8'hFF : 8'h00;
         end
      endcase
      send_pixel(first, second, third);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd10, 8'd200, 8'd10);
      send_pixel(8'd200, 8'd10, 8'd200);
      send_pixel(8'd200, 8'd100, 8'd0);
      send_pixel(8'd0, 8'd100, 8'd200);
      send_pixel(8'd0, 8'd200, 8'd1);
      send_pixel(8'd0, 8'd255, 8'd1);
      send_pixel(8'd0, 8'd100, 8'd1);
      send_pixel(8'd0, 8'd99, 8'd1);
      send_pixel(8'd1, 8'd99, 8'd0);
      send_pixel(8'd128, 8'd127, 8'd126);
      send_pixel(8'd1, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd1);
      send_pixel(8'd254, 8'd255, 8'd253);
      send_pixel(8'd170, 8'd85, 8'd0);
      send_pixel(8'd85, 8'd170, 8'd255);

      for (int mix = 0; mix < 4; mix++) begin
         case (mix)
            0: begin send_idle_pct = 0;  stall_pct <= 0;  end
            1: begin send_idle_pct = 63; stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  stall_pct <= 63; end
            default: begin send_idle_pct = 25; stall_pct <= 25; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (mix == 0 && n == 150) begin
               hold_requests <= hold_requests + 1;
            end
            send_random_pixel();
         end
      end
      req_valid <= 1'b0;
      stall_pct <= 0;

      while (board.pending.size() != 0) begin
         @(posedge clock);
      end
      repeat (2 * LATENCY) @(posedge clock);

      $display("Checked %0d phase words (%0d flat pixels) over corner pixels and four mixes.",
               board.checked, board.flat_pixels);
      $display("Input held back for %0d cycles, mostly during the long output hold.",
               blocked_cycles);
      if (board.clean()) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

>>> sim.f
+incdir+design
design/tpsd_pkg.sv
design/tpsd_front.sv
design/tpsd_cordic_stage.sv
design/tpsd_back.sv
design/three_step_phase_shift_decode_unit.sv
tb/tb.sv
